// ----- design/cart_pkg.sv -----
package cart_pkg;

    localparam int MAX_PACKETS = 1024;
    localparam int HDR_BYTES   = 4;

    // payload field widths
    localparam int SEQ_IN_W = 32;
    localparam int FSZ_W    = 32;
    localparam int PSZ_W    = 16;
    localparam int PLEN_W   = 16;
    localparam int ACK_W    = 11;
    localparam int OFF_W    = 32;
    localparam int LEN_W    = 16;

    // received bitmap, packed into words
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = (MAX_PACKETS + WORD_W - 1) / WORD_W;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SEQ_W     = BIT_W + WIDX_W;
    localparam int CNT_RAW_W = $clog2(MAX_PACKETS + 1);
    localparam int CNT_W     = (CNT_RAW_W > SEQ_W) ? CNT_RAW_W : SEQ_W;

    // ceiling divider: numerator is file_size + payload_size - 1
    localparam int NUM_W     = FSZ_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic OP_INIT = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef enum logic [1:0] {
        ST_INIT_OK  = 2'd0,
        ST_INIT_REJ = 2'd1,
        ST_STORED   = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_DCHK,
        S_RD,
        S_SET,
        S_WRD,
        S_WCHK,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic    in_ready;
        logic    take;
        logic    div_step;
        logic    commit_init;
        logic    reset_xfer;
        logic    clr_step;
        logic    rd_seq;
        logic    set_bit;
        logic    rd_nm;
        logic    nm_inc;
        logic    res_load;
        t_status res_status;
        logic    res_done;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic in_short;
        logic in_psz_zero;
        logic seq_ok;
        logic seq_dup;
        logic active;
        logic div_last;
        logic cnt_over;
        logic nm_lt_cnt;
        logic nm_bit;
        logic done_cond;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- design/cart_in_if.sv -----
interface cart_in_if import cart_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op;
    logic [SEQ_IN_W-1:0] seq;
    logic [FSZ_W-1:0]    file_size;
    logic [PSZ_W-1:0]    payload_size;
    logic [PLEN_W-1:0]   packet_len;

    modport source (
        output valid, op, seq, file_size, payload_size, packet_len,
        input  ready
    );
    modport sink (
        input  valid, op, seq, file_size, payload_size, packet_len,
        output ready
    );
endinterface

// ----- design/cart_out_if.sv -----
interface cart_out_if import cart_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [ACK_W-1:0] ack_seq;
    logic             write_enable;
    logic [OFF_W-1:0] write_offset;
    logic [LEN_W-1:0] write_length;
    logic             done_res;

    modport source (
        output valid, status, ack_seq, write_enable, write_offset, write_length, done_res,
        input  ready
    );
    modport sink (
        input  valid, status, ack_seq, write_enable, write_offset, write_length, done_res,
        output ready
    );
endinterface

// ----- design/cart_ram.sv -----
module cart_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/cart_ctrl.sv -----
module cart_ctrl import cart_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    t_state  r_state, n_state;
    t_status r_kind, n_kind;
    logic    data_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_kind  <= ST_IGNORED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign data_kind = (r_kind == ST_STORED) || (r_kind == ST_IGNORED);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_kind  = r_kind;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.in_op == OP_INIT) begin
                        if (i_sts.in_psz_zero) begin
                            n_kind  = ST_INIT_REJ;
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_DIV;
                        end
                    end else if (!i_sts.in_short) begin
                        if (i_sts.active && i_sts.seq_ok) begin
                            n_state = S_RD;
                        end else begin
                            n_kind  = ST_IGNORED;
                            n_state = S_RESULT;
                        end
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                if (i_sts.cnt_over) begin
                    n_kind = ST_INIT_REJ;
                end else begin
                    o_cmd.commit_init = 1'b1;
                    n_kind            = ST_INIT_OK;
                end
                n_state = S_RESULT;
            end
            S_RD: begin
                o_cmd.rd_seq = 1'b1;
                n_state      = S_SET;
            end
            S_SET: begin
                // packet already seen: ignored, pointer unchanged
                if (i_sts.seq_dup) begin
                    n_kind  = ST_IGNORED;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.set_bit = 1'b1;
                    n_kind        = ST_STORED;
                    n_state       = S_WRD;
                end
            end
            S_WRD: begin
                if (i_sts.nm_lt_cnt) begin
                    o_cmd.rd_nm = 1'b1;
                    n_state     = S_WCHK;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_WCHK: begin
                if (i_sts.nm_bit) begin
                    o_cmd.nm_inc = 1'b1;
                    n_state      = S_WRD;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = r_kind;
                    o_cmd.res_done   = data_kind && i_sts.done_cond;
                    if (o_cmd.res_done || (r_kind == ST_INIT_REJ)) begin
                        o_cmd.reset_xfer = 1'b1;
                    end
                    // init (either outcome) and completion wipe the bitmap
                    if (o_cmd.res_done || !data_kind) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

// ----- design/cart_dp.sv -----
module cart_dp import cart_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    cart_in_if.sink    i_in,
    cart_out_if.source o_out
);
    // transfer state
    logic                 r_active;
    logic [CNT_W-1:0]     r_count;
    logic [PSZ_W-1:0]     r_psz_st;
    logic [CNT_W-1:0]     r_nm;
    logic [WIDX_W-1:0]    r_clr_idx;

    // latched beat and divider
    logic [SEQ_IN_W-1:0]  r_seq;
    logic [PLEN_W-1:0]    r_plen;
    logic [NUM_W-1:0]     r_dq;
    logic [PSZ_W-1:0]     r_rem;
    logic [PSZ_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [OFF_W-1:0]     r_off;
    logic [LEN_W-1:0]     r_len;

    // output register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [ACK_W-1:0]     r_out_ack;
    logic                 r_out_we;
    logic [OFF_W-1:0]     r_out_off;
    logic [LEN_W-1:0]     r_out_len;
    logic                 r_out_done;

    logic [PSZ_W:0]       rem_sh;
    logic [PSZ_W:0]       rem_diff;
    logic                 rem_fits;
    logic [WIDX_W-1:0]    seq_word;
    logic [BIT_W-1:0]     seq_bit;
    logic [WIDX_W-1:0]    nm_word;
    logic [BIT_W-1:0]     nm_bit;
    logic [SEQ_W+PSZ_W-1:0] prod;
    logic                 ram_we;
    logic [WIDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WIDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;
    logic                 out_free;
    logic                 res_is_data;

    assign seq_word = r_seq[BIT_W +: WIDX_W];
    assign seq_bit  = r_seq[BIT_W-1:0];
    assign nm_word  = r_nm[BIT_W +: WIDX_W];
    assign nm_bit   = r_nm[BIT_W-1:0];

    assign rem_sh   = {r_rem, r_dq[NUM_W-1]};
    assign rem_fits = rem_sh >= {1'b0, r_div};
    assign rem_diff = rem_sh - {1'b0, r_div};

    assign prod = r_seq[SEQ_W-1:0] * r_psz_st;

    assign ram_we    = i_cmd.clr_step || i_cmd.set_bit;
    assign ram_waddr = i_cmd.clr_step ? r_clr_idx : seq_word;
    assign ram_wdata = i_cmd.clr_step ? '0 : (ram_rdata | (WORD_W'(1) << seq_bit));
    assign ram_raddr = i_cmd.rd_nm ? nm_word : seq_word;

    cart_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_out_valid || o_out.ready;
    assign res_is_data = (i_cmd.res_status == ST_STORED) || (i_cmd.res_status == ST_IGNORED);

    always_comb begin
        o_sts.in_valid    = i_in.valid;
        o_sts.in_op       = i_in.op;
        o_sts.in_short    = i_in.packet_len < PLEN_W'(HDR_BYTES);
        o_sts.in_psz_zero = i_in.payload_size == '0;
        o_sts.seq_ok      = i_in.seq < SEQ_IN_W'(r_count);
        o_sts.seq_dup     = ram_rdata[seq_bit];
        o_sts.active      = r_active;
        o_sts.div_last    = r_div_cnt == DIV_CNT_W'(NUM_W - 1);
        o_sts.cnt_over    = r_dq > NUM_W'(MAX_PACKETS);
        o_sts.nm_lt_cnt   = r_nm < r_count;
        o_sts.nm_bit      = ram_rdata[nm_bit];
        o_sts.done_cond   = r_active && (r_nm == r_count);
        o_sts.clr_last    = r_clr_idx == WIDX_W'(NUM_WORDS - 1);
        o_sts.out_free    = out_free;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_count     <= '0;
            r_psz_st    <= '0;
            r_nm        <= '0;
            r_clr_idx   <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit_init) begin
                r_active <= 1'b1;
                r_count  <= CNT_W'(r_dq);
                r_psz_st <= r_div;
                r_nm     <= '0;
            end else if (i_cmd.reset_xfer) begin
                r_active <= 1'b0;
                r_count  <= '0;
                r_psz_st <= '0;
                r_nm     <= '0;
            end else if (i_cmd.nm_inc) begin
                r_nm <= r_nm + CNT_W'(1);
            end

            if (i_cmd.clr_step) begin
                r_clr_idx <= o_sts.clr_last ? '0 : r_clr_idx + WIDX_W'(1);
            end

            if (i_cmd.take) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end

            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_seq  <= i_in.seq;
            r_plen <= i_in.packet_len;
            r_dq   <= {1'b0, i_in.file_size} + NUM_W'(i_in.payload_size) - NUM_W'(1);
            r_rem  <= '0;
            r_div  <= i_in.payload_size;
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[NUM_W-2:0], rem_fits};
            r_rem <= rem_fits ? rem_diff[PSZ_W-1:0] : rem_sh[PSZ_W-1:0];
        end

        if (i_cmd.set_bit) begin
            r_off <= OFF_W'(prod);
            r_len <= LEN_W'(r_plen - PLEN_W'(HDR_BYTES));
        end

        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.res_status;
            r_out_ack    <= res_is_data ? ACK_W'(r_nm) : '0;
            r_out_we     <= i_cmd.res_status == ST_STORED;
            r_out_off    <= (i_cmd.res_status == ST_STORED) ? r_off : '0;
            r_out_len    <= (i_cmd.res_status == ST_STORED) ? r_len : '0;
            r_out_done   <= i_cmd.res_done;
        end
    end

    assign i_in.ready         = i_cmd.in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.ack_seq      = r_out_ack;
    assign o_out.write_enable = r_out_we;
    assign o_out.write_offset = r_out_off;
    assign o_out.write_length = r_out_len;
    assign o_out.done_res     = r_out_done;
endmodule

// ----- design/cumulative_ack_receive_tracker.sv -----
// channel  dir  fields
// i_in     in   op, seq, file_size, payload_size, packet_len
// o_out    out  status, ack_seq, write_enable, write_offset, write_length, done_res
//
// One beat at a time. Stored beat: bitmap word read, bit set, ack pointer walked
// past received packets up to the count, then result. Ignored beats go to result
// (duplicates after the read); short data beats give none. Init: serial ceiling
// divider, count check, result; zero payload size is rejected at once. Init,
// reject and completion then clear the bitmap one word per cycle, as does reset
// before the first beat. Results sit in an output register; the next beat is
// taken while one waits; a new result stalls only until the previous one is taken.
module cumulative_ack_receive_tracker import cart_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cart_in_if.sink    i_in,
    cart_out_if.source o_out
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    cart_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cart_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule
